// File: rtl/tapg_pkg.sv
// Shared types and constants for the triangle area penalty gradient block.
// Used by tapg_serial_unit, the top level, both checkers and the testbench; depends on nothing.
package tapg_pkg;

    // Fixed-point format of coordinates, area and gradients
    localparam int FRAC_BITS = 16;
    // |N'|^2 is scaled down by this shift before the area root
    localparam int SQ_SHIFT  = 2 * FRAC_BITS - 2;

    // Serial unit last step indexes (one bit, or one root digit, per cycle)
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(63);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(127);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(63);

    // Saturation limits
    localparam logic [63:0] AREA_MAX   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [47:0] GRAD_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] GRAD_MIN   = 48'h8000_0000_0000;
    localparam logic [62:0] ENERGY_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_AREA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 1'b1;

    // Stream payload layout
    localparam int IN_W       = 288;
    localparam int OUT_W      = 304;
    localparam int USER_W     = 3;
    localparam int GX_LSB     = 0;
    localparam int GY_LSB     = 48;
    localparam int GZ_LSB     = 96;
    localparam int AREA_LSB   = 144;
    localparam int DEV_LSB    = 191;
    localparam int ENERGY_LSB = 239;
    localparam int ENERGY_W   = 63;
    localparam int USER_DONE  = 2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } su_op_t;

    // Request to the serial arithmetic unit
    typedef struct packed {
        logic         start;
        su_op_t       op;
        logic [127:0] opa;   // mul: multiplicand [63:0]; div: dividend; sqrt: radicand
        logic [63:0]  opb;   // mul: multiplier; div: divisor
    } su_req_t;

    // Response from the serial arithmetic unit
    typedef struct packed {
        logic         done;  // one-cycle pulse, res holds until the next start
        logic [127:0] res;
    } su_rsp_t;

endpackage

// File: rtl/tapg_serial_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one bit (or one root digit) per cycle.
// Depends on tapg_pkg.
module tapg_serial_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  tapg_pkg::su_req_t req,
    output tapg_pkg::su_rsp_t rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    tapg_pkg::su_op_t           op_reg, op_next;
    logic [tapg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [127:0]               acc_reg, acc_next;
    logic [63:0]                opd_reg, opd_next;
    logic [65:0]                rem_reg, rem_next;
    logic [63:0]                root_reg, root_next;

    logic [64:0] mul_sum;
    logic [64:0] div_r2;
    logic [64:0] div_diff;
    logic [67:0] sq_r2;
    logic [67:0] sq_trial;
    logic [67:0] sq_diff;

    always_comb
    begin
        mul_sum  = {1'b0, acc_reg[127:64]} + (acc_reg[0] ? {1'b0, opd_reg} : 65'd0);
        div_r2   = {rem_reg[63:0], acc_reg[127]};
        div_diff = div_r2 - {1'b0, opd_reg};
        sq_r2    = {rem_reg, acc_reg[127:126]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_diff  = sq_r2 - sq_trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opd_next  = opd_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            rem_next  = '0;
            root_next = '0;
            case (req.op)
                tapg_pkg::OP_MUL:
                begin
                    acc_next = {64'd0, req.opb};
                    opd_next = req.opa[63:0];
                    cnt_next = tapg_pkg::MUL_LAST;
                end
                tapg_pkg::OP_DIV:
                begin
                    acc_next = req.opa;
                    opd_next = req.opb;
                    cnt_next = tapg_pkg::DIV_LAST;
                end
                tapg_pkg::OP_SQRT:
                begin
                    acc_next = req.opa;
                    cnt_next = tapg_pkg::SQRT_LAST;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                tapg_pkg::OP_MUL:
                begin
                    acc_next = {mul_sum, acc_reg[63:1]};
                end
                tapg_pkg::OP_DIV:
                begin
                    if (div_r2 >= {1'b0, opd_reg})
                    begin
                        rem_next = {2'b00, div_diff[63:0]};
                        acc_next = {acc_reg[126:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {1'b0, div_r2};
                        acc_next = {acc_reg[126:0], 1'b0};
                    end
                end
                tapg_pkg::OP_SQRT:
                begin
                    acc_next = {acc_reg[125:0], 2'b00};
                    if (sq_r2 >= sq_trial)
                    begin
                        rem_next  = sq_diff[65:0];
                        root_next = {root_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = sq_r2[65:0];
                        root_next = {root_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= tapg_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opd_reg  <= opd_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == tapg_pkg::OP_SQRT) ? {64'd0, root_reg} : acc_reg;

endmodule

// File: rtl/triangle_area_penalty_gradient_top.sv
// Triangle area penalty gradient, top level: stream ports, config registers,
// sequencer and output register. Depends on tapg_pkg and tapg_serial_unit.
//
// One triangle (three Q16.16 vertices) per input transaction gives three output
// transactions, one per corner, each carrying the scaled area gradient, the area,
// the deviation from ref_area and, on the third corner of the last triangle, the
// mesh energy. All wide arithmetic runs through one shared bit-serial unit, one
// bit (or one root digit) per cycle plus issue and collect for each operation.
// A triangle needs 38 multiplies, 2 roots and 10 divides; the last triangle of
// a mesh adds one multiply and one divide. A zero ref_area drops one divide
// (two on the last triangle), and a degenerate triangle drops nine. Output
// back-pressure adds its stall cycles. s_axis_tready is high only between
// triangles; the third result may still sit in the output register while the
// next triangle starts. Configuration writes are taken any time but must only
// be made while idle.
module triangle_area_penalty_gradient_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream tdata: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each)
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tapg_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic                          s_axis_tlast,   // last_triangle
    // master stream tdata: grad_x(48), grad_y(48), grad_z(48), area(47),
    // area_dev(48), energy(63), 2 zero pad bits
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tapg_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic [tapg_pkg::USER_W-1:0]   m_axis_tuser,   // corner(2), mesh_done(1)
    output logic                          m_axis_tlast,   // run_last
    // configuration write port
    input  logic                          cfg_we,
    input  logic [tapg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]                   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NRM_P1,
        S_NRM_P2,
        S_NRM_SQ,
        S_AREA,
        S_LEN,
        S_COEF_MUL,
        S_COEF_DIV,
        S_DEV_SQ,
        S_EN_MUL,
        S_EN_DIV,
        S_G_P1,
        S_G_P2,
        S_G_DIV,
        S_G_SCL,
        S_EMIT
    } state_t;

    // ---- config registers ----
    logic [30:0] ref_area_reg;
    logic [30:0] stiffness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_area_reg  <= '0;
            stiffness_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tapg_pkg::CFG_REF_AREA:  ref_area_reg  <= cfg_data;
                tapg_pkg::CFG_STIFFNESS: stiffness_reg <= cfg_data;
                default:                 ref_area_reg  <= ref_area_reg;
            endcase
        end
    end

    // ---- sequencer state ----
    state_t              state_reg, state_next;
    logic                pend_reg, pend_next;       // op issued, waiting for done
    logic [1:0]          idx_reg, idx_next;         // vector component
    logic [1:0]          crn_reg, crn_next;         // corner
    logic                last_reg, last_next;
    logic signed [32:0]  u_reg [3];                 // b - a
    logic signed [32:0]  v_reg [3];                 // c - a
    logic signed [32:0]  w_reg [3];                 // b - c
    logic signed [32:0]  u_next [3];
    logic signed [32:0]  v_next [3];
    logic signed [32:0]  w_next [3];
    logic                nv_neg_reg [3];            // scaled normal, sign/magnitude
    logic                nv_neg_next [3];
    logic [62:0]         nv_mag_reg [3];
    logic [62:0]         nv_mag_next [3];
    logic [127:0]        s_reg, s_next;             // |N'|^2
    logic signed [96:0]  p1_reg, p1_next;           // first product of a cross term
    logic [127:0]        num_reg, num_next;         // pending dividend
    logic [46:0]         area_reg, area_next;
    logic signed [47:0]  dev_reg, dev_next;
    logic [63:0]         len_reg, len_next;
    logic [63:0]         cmag_reg, cmag_next;
    logic [63:0]         esum_reg, esum_next;
    logic [62:0]         energy_reg, energy_next;
    logic                xneg_reg, xneg_next;
    logic [63:0]         g_reg, g_next;
    logic [47:0]         grad_reg [3];
    logic [47:0]         grad_next [3];

    // ---- output register ----
    logic                         ovalid_reg, ovalid_next;
    logic [tapg_pkg::OUT_W-1:0]   odata_reg, odata_next;
    logic [tapg_pkg::USER_W-1:0]  ouser_reg, ouser_next;
    logic                         olast_reg, olast_next;

    // ---- serial unit ----
    tapg_pkg::su_req_t req;
    tapg_pkg::su_rsp_t rsp;

    tapg_serial_unit u_su (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ---- helpers ----
    function automatic logic [31:0] mag33(input logic [32:0] x);
        logic [32:0] n;
        n = x[32] ? (33'd0 - x) : x;
        return n[31:0];
    endfunction

    function automatic logic [63:0] sat64(input logic [127:0] x);
        return (|x[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : x[63:0];
    endfunction

    function automatic logic [62:0] clamp63(input logic [63:0] x);
        return x[63] ? tapg_pkg::ENERGY_MAX : x[62:0];
    endfunction

    function automatic logic [96:0] smul(input logic neg, input logic [95:0] m);
        logic [96:0] e;
        e = {1'b0, m};
        return neg ? (97'd0 - e) : e;
    endfunction

    // ---- datapath helpers ----
    logic [1:0]          j_idx, l_idx;
    logic signed [32:0]  evec [3];
    logic                prod_neg;
    logic [96:0]         prod_s;
    logic [97:0]         diff;
    logic [97:0]         dabs;
    logic                dneg;
    logic [47:0]         devmag;
    logic [46:0]         area_val;
    logic [63:0]         pval;
    logic                gneg;
    logic [47:0]         rmag;
    logic [127:0]        coef_t;
    logic [63:0]         sq_val;
    logic [64:0]         esum_sum;
    logic                run_state;
    logic                out_free;
    logic                in_acc;

    always_comb
    begin
        case (idx_reg)
            2'd0:    begin j_idx = 2'd1; l_idx = 2'd2; end
            2'd1:    begin j_idx = 2'd2; l_idx = 2'd0; end
            default: begin j_idx = 2'd0; l_idx = 2'd1; end
        endcase

        for (int c = 0; c < 3; c++)
        begin
            case (crn_reg)
                2'd0:    evec[c] = w_reg[c];
                2'd1:    evec[c] = v_reg[c];
                default: evec[c] = 33'sd0 - u_reg[c];
            endcase
        end

        case (state_reg)
            S_NRM_P1: prod_neg = u_reg[j_idx][32] ^ v_reg[l_idx][32];
            S_NRM_P2: prod_neg = u_reg[l_idx][32] ^ v_reg[j_idx][32];
            S_G_P1:   prod_neg = evec[j_idx][32] ^ nv_neg_reg[l_idx];
            S_G_P2:   prod_neg = evec[l_idx][32] ^ nv_neg_reg[j_idx];
            default:  prod_neg = 1'b0;
        endcase

        prod_s = smul(prod_neg, rsp.res[95:0]);
        diff   = {p1_reg[96], p1_reg} - {prod_s[96], prod_s};
        dneg   = diff[97];
        dabs   = dneg ? (98'd0 - diff) : diff;

        devmag   = dev_reg[47] ? (48'd0 - dev_reg) : dev_reg;
        area_val = (rsp.res[63:0] > tapg_pkg::AREA_MAX) ? tapg_pkg::AREA_MAX[46:0]
                                                        : rsp.res[46:0];
        coef_t   = {rsp.res[126:0], 1'b0};
        sq_val   = sat64(rsp.res >> tapg_pkg::FRAC_BITS);
        esum_sum = {1'b0, esum_reg} + {1'b0, sq_val};

        pval = sat64(rsp.res >> tapg_pkg::FRAC_BITS);
        gneg = (xneg_reg != dev_reg[47]) && (pval != 64'd0);
        if (pval > {16'd0, tapg_pkg::GRAD_MAX})
            rmag = gneg ? tapg_pkg::GRAD_MIN : tapg_pkg::GRAD_MAX;
        else
            rmag = pval[47:0];

        run_state = (state_reg != S_IDLE) && (state_reg != S_EMIT);
        out_free  = !ovalid_reg || m_axis_tready;
        in_acc    = s_axis_tvalid && (state_reg == S_IDLE);
    end

    // ---- operand selection for the serial unit ----
    always_comb
    begin
        req.start = run_state && !pend_reg;
        req.op    = tapg_pkg::OP_MUL;
        req.opa   = '0;
        req.opb   = '0;
        case (state_reg)
            S_NRM_P1:
            begin
                req.opa = {96'd0, mag33(u_reg[j_idx])};
                req.opb = {32'd0, mag33(v_reg[l_idx])};
            end
            S_NRM_P2:
            begin
                req.opa = {96'd0, mag33(u_reg[l_idx])};
                req.opb = {32'd0, mag33(v_reg[j_idx])};
            end
            S_NRM_SQ:
            begin
                req.opa = {65'd0, nv_mag_reg[idx_reg]};
                req.opb = {1'b0, nv_mag_reg[idx_reg]};
            end
            S_AREA:
            begin
                req.op  = tapg_pkg::OP_SQRT;
                req.opa = s_reg >> tapg_pkg::SQ_SHIFT;
            end
            S_LEN:
            begin
                req.op  = tapg_pkg::OP_SQRT;
                req.opa = s_reg;
            end
            S_COEF_MUL:
            begin
                req.opa = {97'd0, stiffness_reg};
                req.opb = {16'd0, devmag};
            end
            S_COEF_DIV, S_EN_DIV:
            begin
                req.op  = tapg_pkg::OP_DIV;
                req.opa = num_reg;
                req.opb = {33'd0, ref_area_reg};
            end
            S_DEV_SQ:
            begin
                req.opa = {80'd0, devmag};
                req.opb = {16'd0, devmag};
            end
            S_EN_MUL:
            begin
                req.opa = {97'd0, stiffness_reg};
                req.opb = esum_reg;
            end
            S_G_P1:
            begin
                req.opa = {96'd0, mag33(evec[j_idx])};
                req.opb = {1'b0, nv_mag_reg[l_idx]};
            end
            S_G_P2:
            begin
                req.opa = {96'd0, mag33(evec[l_idx])};
                req.opb = {1'b0, nv_mag_reg[j_idx]};
            end
            S_G_DIV:
            begin
                req.op  = tapg_pkg::OP_DIV;
                req.opa = num_reg;
                req.opb = len_reg;
            end
            S_G_SCL:
            begin
                req.opa = {64'd0, g_reg};
                req.opb = cmag_reg;
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    // ---- next-state logic ----
    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        idx_next    = idx_reg;
        crn_next    = crn_reg;
        last_next   = last_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        w_next      = w_reg;
        nv_neg_next = nv_neg_reg;
        nv_mag_next = nv_mag_reg;
        s_next      = s_reg;
        p1_next     = p1_reg;
        num_next    = num_reg;
        area_next   = area_reg;
        dev_next    = dev_reg;
        len_next    = len_reg;
        cmag_next   = cmag_reg;
        esum_next   = esum_reg;
        energy_next = energy_reg;
        xneg_next   = xneg_reg;
        g_next      = g_reg;
        grad_next   = grad_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        if (req.start)
            pend_next = 1'b1;
        if (rsp.done)
            pend_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        u_next[c] = $signed({s_axis_tdata[96 + 32*c + 31],
                                             s_axis_tdata[96 + 32*c +: 32]})
                                  - $signed({s_axis_tdata[32*c + 31],
                                             s_axis_tdata[32*c +: 32]});
                        v_next[c] = $signed({s_axis_tdata[192 + 32*c + 31],
                                             s_axis_tdata[192 + 32*c +: 32]})
                                  - $signed({s_axis_tdata[32*c + 31],
                                             s_axis_tdata[32*c +: 32]});
                        w_next[c] = $signed({s_axis_tdata[96 + 32*c + 31],
                                             s_axis_tdata[96 + 32*c +: 32]})
                                  - $signed({s_axis_tdata[192 + 32*c + 31],
                                             s_axis_tdata[192 + 32*c +: 32]});
                    end
                    last_next   = s_axis_tlast;
                    s_next      = '0;
                    energy_next = '0;
                    idx_next    = 2'd0;
                    crn_next    = 2'd0;
                    state_next  = S_NRM_P1;
                end
            end
            S_NRM_P1:
            begin
                if (rsp.done)
                begin
                    p1_next    = prod_s;
                    state_next = S_NRM_P2;
                end
            end
            S_NRM_P2:
            begin
                if (rsp.done)
                begin
                    nv_neg_next[idx_reg] = dneg;
                    nv_mag_next[idx_reg] = dabs[64:2];
                    state_next           = S_NRM_SQ;
                end
            end
            S_NRM_SQ:
            begin
                if (rsp.done)
                begin
                    s_next = s_reg + rsp.res;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = 2'd0;
                        state_next = S_AREA;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_NRM_P1;
                    end
                end
            end
            S_AREA:
            begin
                if (rsp.done)
                begin
                    area_next  = area_val;
                    dev_next   = $signed({1'b0, area_val}) - $signed({17'd0, ref_area_reg});
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (rsp.done)
                begin
                    len_next   = rsp.res[63:0];
                    state_next = S_COEF_MUL;
                end
            end
            S_COEF_MUL:
            begin
                if (rsp.done)
                begin
                    if (ref_area_reg == '0)
                    begin
                        cmag_next  = sat64(coef_t >> tapg_pkg::FRAC_BITS);
                        state_next = S_DEV_SQ;
                    end
                    else
                    begin
                        num_next   = coef_t;
                        state_next = S_COEF_DIV;
                    end
                end
            end
            S_COEF_DIV:
            begin
                if (rsp.done)
                begin
                    cmag_next  = sat64(rsp.res);
                    state_next = S_DEV_SQ;
                end
            end
            S_DEV_SQ:
            begin
                if (rsp.done)
                begin
                    esum_next  = esum_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : esum_sum[63:0];
                    state_next = last_reg ? S_EN_MUL : S_G_P1;
                end
            end
            S_EN_MUL:
            begin
                if (rsp.done)
                begin
                    esum_next = '0;
                    if (ref_area_reg == '0)
                    begin
                        energy_next = clamp63(sat64(rsp.res >> tapg_pkg::FRAC_BITS));
                        state_next  = S_G_P1;
                    end
                    else
                    begin
                        num_next   = rsp.res;
                        state_next = S_EN_DIV;
                    end
                end
            end
            S_EN_DIV:
            begin
                if (rsp.done)
                begin
                    energy_next = clamp63(sat64(rsp.res));
                    state_next  = S_G_P1;
                end
            end
            S_G_P1:
            begin
                if (rsp.done)
                begin
                    p1_next    = prod_s;
                    state_next = S_G_P2;
                end
            end
            S_G_P2:
            begin
                if (rsp.done)
                begin
                    xneg_next = dneg;
                    num_next  = {33'd0, dabs[95:1]};
                    if (len_reg == '0)
                    begin
                        g_next     = '0;
                        state_next = S_G_SCL;
                    end
                    else
                    begin
                        state_next = S_G_DIV;
                    end
                end
            end
            S_G_DIV:
            begin
                if (rsp.done)
                begin
                    g_next     = sat64(rsp.res);
                    state_next = S_G_SCL;
                end
            end
            S_G_SCL:
            begin
                if (rsp.done)
                begin
                    grad_next[idx_reg] = gneg ? (48'd0 - rmag) : rmag;
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = 2'd0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_G_P1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    odata_next[tapg_pkg::GX_LSB +: 48]   = grad_reg[0];
                    odata_next[tapg_pkg::GY_LSB +: 48]   = grad_reg[1];
                    odata_next[tapg_pkg::GZ_LSB +: 48]   = grad_reg[2];
                    odata_next[tapg_pkg::AREA_LSB +: 47] = area_reg;
                    odata_next[tapg_pkg::DEV_LSB +: 48]  = dev_reg;
                    odata_next[tapg_pkg::ENERGY_LSB +: tapg_pkg::ENERGY_W] =
                        (crn_reg == 2'd2 && last_reg) ? energy_reg : '0;
                    ouser_next = {(crn_reg == 2'd2) && last_reg, crn_reg};
                    olast_next = (crn_reg == 2'd2);
                    if (crn_reg == 2'd2)
                    begin
                        crn_next   = 2'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        crn_next   = crn_reg + 2'd1;
                        state_next = S_G_P1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
            crn_reg    <= '0;
            last_reg   <= 1'b0;
            esum_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                u_reg[c]      <= '0;
                v_reg[c]      <= '0;
                w_reg[c]      <= '0;
                nv_neg_reg[c] <= 1'b0;
                nv_mag_reg[c] <= '0;
                grad_reg[c]   <= '0;
            end
            s_reg      <= '0;
            p1_reg     <= '0;
            num_reg    <= '0;
            area_reg   <= '0;
            dev_reg    <= '0;
            len_reg    <= '0;
            cmag_reg   <= '0;
            energy_reg <= '0;
            xneg_reg   <= 1'b0;
            g_reg      <= '0;
            odata_reg  <= '0;
            ouser_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            idx_reg    <= idx_next;
            crn_reg    <= crn_next;
            last_reg   <= last_next;
            esum_reg   <= esum_next;
            ovalid_reg <= ovalid_next;
            u_reg      <= u_next;
            v_reg      <= v_next;
            w_reg      <= w_next;
            nv_neg_reg <= nv_neg_next;
            nv_mag_reg <= nv_mag_next;
            grad_reg   <= grad_next;
            s_reg      <= s_next;
            p1_reg     <= p1_next;
            num_reg    <= num_next;
            area_reg   <= area_next;
            dev_reg    <= dev_next;
            len_reg    <= len_next;
            cmag_reg   <= cmag_next;
            energy_reg <= energy_next;
            xneg_reg   <= xneg_next;
            g_reg      <= g_next;
            odata_reg  <= odata_next;
            ouser_reg  <= ouser_next;
            olast_reg  <= olast_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// File: rtl/tapg_checker.sv
// Port-level checks on the result stream of the triangle area penalty block,
// bound to the top level. Depends on tapg_pkg.
module tapg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [tapg_pkg::OUT_W-1:0]   m_axis_tdata,
    input logic [tapg_pkg::USER_W-1:0]  m_axis_tuser,
    input logic                         m_axis_tlast
);

    // tlast marks the third corner and only that one
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == 2'd2)))
        else $error("tlast does not match corner two");

    // mesh end only on a triangle's last corner
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[tapg_pkg::USER_DONE]) |-> m_axis_tlast)
        else $error("mesh_done without tlast");

    // energy is zero except at mesh end
    a_energy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[tapg_pkg::USER_DONE]) |->
        (m_axis_tdata[tapg_pkg::ENERGY_LSB +: tapg_pkg::ENERGY_W] == '0))
        else $error("energy nonzero before mesh end");

    // a result taken before the last corner is not followed at once by corner 0
    a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (!m_axis_tvalid || (m_axis_tuser[1:0] != 2'd0)))
        else $error("corner sequence broken");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind triangle_area_penalty_gradient_top tapg_checker u_tapg_checker (.*);

// File: dv/tapg_checker.sv
// Checker for triangle_area_penalty_gradient_top: predicts the three corner
// results of each accepted triangle and compares them on the output stream.
// Depends on tapg_pkg.
`timescale 1ns / 100ps

module tapg_tb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [tapg_pkg::IN_W-1:0]      s_axis_tdata,
    input  logic                           s_axis_tlast,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [tapg_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic [tapg_pkg::USER_W-1:0]    m_axis_tuser,
    input  logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [tapg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]                    cfg_data,
    output int                             fail_count,
    output int                             pending
);

    typedef struct packed {
        logic [1:0]  corner;
        logic [47:0] gx;
        logic [47:0] gy;
        logic [47:0] gz;
        logic [46:0] area;
        logic [47:0] dev;
        logic [62:0] energy;
        logic        run_last;
        logic        mesh_done;
    } corner_res_t;

    corner_res_t corner_q[$];

    logic [63:0] a0_q;
    logic [63:0] k_q;
    logic [63:0] dev_sq_sum;

    function automatic logic [63:0] sat64(input logic [127:0] v);
        return (|v[127:64]) ? {64{1'b1}} : v[63:0];
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tt;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t  = r | (64'd1 << b);
            tt = 128'(t) * 128'(t);
            if (tt <= v)
                r = t;
        end
        return r;
    endfunction

    // p*q - r*s, exact
    function automatic logic signed [129:0] xprod(input logic signed [129:0] p, q, r, s);
        return p * q - r * s;
    endfunction

    task automatic predict_triangle(input logic [tapg_pkg::IN_W-1:0] d, input logic lst);
        logic signed [129:0] va [3];
        logic signed [129:0] vb [3];
        logic signed [129:0] vc [3];
        logic signed [129:0] u  [3];
        logic signed [129:0] v  [3];
        logic signed [129:0] e  [3];
        logic signed [63:0]  nrm[3];
        logic signed [129:0] x;
        logic [129:0]        xm;
        logic [63:0]         m, area, len, cmag, g, p, rr, en;
        logic [127:0]        s, t;
        logic signed [63:0]  dev;
        logic [63:0]         dmag;
        logic                cneg, neg;
        logic [47:0]         gr [3];
        corner_res_t         res;
        int                  j, l;
        for (int i = 0; i < 3; i++) begin
            va[i] = $signed(d[32*i +: 32]);
            vb[i] = $signed(d[32*(3+i) +: 32]);
            vc[i] = $signed(d[32*(6+i) +: 32]);
            u[i]  = vb[i] - va[i];
            v[i]  = vc[i] - va[i];
        end
        s = '0;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            l = (i + 2) % 3;
            x  = xprod(u[j], v[l], u[l], v[j]);
            xm = x < 0 ? -x : x;
            m  = xm[65:2];
            nrm[i] = x < 0 ? -m : m;
            s = s + 128'(m) * 128'(m);
        end
        area = isqrt(s >> tapg_pkg::SQ_SHIFT);
        if (area > tapg_pkg::AREA_MAX)
            area = tapg_pkg::AREA_MAX;
        len  = isqrt(s);
        dev  = $signed(area) - $signed(a0_q);
        cneg = dev < 0;
        dmag = cneg ? -dev : dev;

        t = 128'(k_q) * 128'(dmag);
        t = t + t;
        t = (a0_q != 0) ? t / 128'(a0_q) : t >> tapg_pkg::FRAC_BITS;
        cmag = sat64(t);

        m = sat64((128'(dmag) * 128'(dmag)) >> tapg_pkg::FRAC_BITS);
        dev_sq_sum = ({64{1'b1}} - dev_sq_sum < m) ? {64{1'b1}} : dev_sq_sum + m;
        en = '0;
        if (lst) begin
            t  = 128'(k_q) * 128'(dev_sq_sum);
            t  = (a0_q != 0) ? t / 128'(a0_q) : t >> tapg_pkg::FRAC_BITS;
            en = sat64(t);
            if (en > 64'(tapg_pkg::ENERGY_MAX))
                en = 64'(tapg_pkg::ENERGY_MAX);
            dev_sq_sum = '0;
        end

        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0)      e[i] = vb[i] - vc[i];
                else if (k == 1) e[i] = vc[i] - va[i];
                else             e[i] = va[i] - vb[i];
            end
            for (int i = 0; i < 3; i++) begin
                j = (i + 1) % 3;
                l = (i + 2) % 3;
                x  = xprod(e[j], 130'(nrm[l]), e[l], 130'(nrm[j]));
                xm = x < 0 ? -x : x;
                g  = (len != 0) ? sat64(xm[127:0] >> 1) : '0;
                if (len != 0)
                    g = sat64((xm[127:0] >> 1) / 128'(len));
                p   = sat64((128'(g) * 128'(cmag)) >> tapg_pkg::FRAC_BITS);
                neg = ((x < 0) != cneg) && (p != 0);
                if (neg)
                    rr = (p > 64'(tapg_pkg::GRAD_MAX)) ? 64'd1 << 47 : p;
                else
                    rr = (p > 64'(tapg_pkg::GRAD_MAX)) ? 64'(tapg_pkg::GRAD_MAX) : p;
                gr[i] = neg ? 48'(-rr) : rr[47:0];
            end
            res.corner    = 2'(k);
            res.gx        = gr[0];
            res.gy        = gr[1];
            res.gz        = gr[2];
            res.area      = area[46:0];
            res.dev       = dev[47:0];
            res.energy    = (k == 2 && lst) ? en[62:0] : '0;
            res.run_last  = (k == 2);
            res.mesh_done = (k == 2 && lst);
            corner_q.push_back(res);
        end
    endtask

    corner_res_t got, exp_r;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a0_q       = '0;
            k_q        = 64'd65536;
            dev_sq_sum = '0;
            fail_count = 0;
            corner_q.delete();
            pending    = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == tapg_pkg::CFG_REF_AREA)
                    a0_q = 64'(cfg_data);
                else if (cfg_index == tapg_pkg::CFG_STIFFNESS)
                    k_q = 64'(cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_triangle(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.corner    = m_axis_tuser[1:0];
                got.gx        = m_axis_tdata[tapg_pkg::GX_LSB +: 48];
                got.gy        = m_axis_tdata[tapg_pkg::GY_LSB +: 48];
                got.gz        = m_axis_tdata[tapg_pkg::GZ_LSB +: 48];
                got.area      = m_axis_tdata[tapg_pkg::AREA_LSB +: 47];
                got.dev       = m_axis_tdata[tapg_pkg::DEV_LSB +: 48];
                got.energy    = m_axis_tdata[tapg_pkg::ENERGY_LSB +: tapg_pkg::ENERGY_W];
                got.run_last  = m_axis_tlast;
                got.mesh_done = m_axis_tuser[tapg_pkg::USER_DONE];
                if (corner_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %p", got);
                end
                else begin
                    exp_r = corner_q.pop_front();
                    if (got != exp_r) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %p", exp_r);
                            $display("          actual   %p", got);
                        end
                    end
                end
            end
            pending = corner_q.size();
        end
    end

endmodule

// File: dv/tb.sv
// Testbench top for triangle_area_penalty_gradient_top: clock, reset,
// triangle stimulus, config phases and verdict. Depends on tapg_pkg, tapg_tb_checker.
`timescale 1ns / 100ps

module tb;

    localparam int WDOG_LIMIT = 60000;   // must cover one triangle's computation plus stalls
    localparam int RAND_ITEMS = 155;
    localparam int Q1         = 65536;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tapg_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [tapg_pkg::OUT_W-1:0]     m_axis_tdata;
    logic [tapg_pkg::USER_W-1:0]    m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           cfg_we = 1'b0;
    logic [tapg_pkg::CFG_IDX_W-1:0] cfg_index = tapg_pkg::CFG_REF_AREA;
    logic [30:0]                    cfg_data = '0;

    int  fails;
    int  pending;
    int  idle_cycles = 0;
    bit  no_stall = 1'b0;     // stretches with no idling on either side
    int  out_hold = 0;

    always #5 clk = ~clk;

    triangle_area_penalty_gradient_top DUT (.*);

    tapg_tb_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fails), .pending(pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_stall)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(20, 300);
    endfunction

    // Receiver back-pressure, changed at the falling edge
    always @(negedge clk) begin
        if (out_hold > 0) begin
            m_axis_tready <= 1'b0;
            out_hold <= out_hold - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                out_hold <= pick_gap();
        end
    end

    // Watchdog: cycles with no transaction on either stream
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("** triangle_area_penalty_gradient_top: FAILED **");
            $finish;
        end
    end

    // One triangle transaction; entered and left at a falling edge
    task automatic send_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz, input bit lst);
        int  n;
        bit  ok;
        n = pick_gap();
        if (n > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tdata  = {cz, cy, cx, bz, by, bx, az, ay, ax};
        s_axis_tlast  = lst;
        s_axis_tvalid = 1'b1;
        ok = 1'b0;
        while (!ok) begin
            #1;
            ok = s_axis_tready;
            @(negedge clk);
        end
    endtask

    task automatic cfg_write(input logic [tapg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [30:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Config changes only with the block drained
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic rand_coord(output int c, input int mode);
        case (mode)
            0: c = $urandom;
            1: c = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            2: c = int'($urandom_range(0, 1 << 27)) - (1 << 26);
            default: c = int'($urandom_range(0, 1 << 17)) - (1 << 16);
        endcase
    endtask

    task automatic rand_tri();
        int  v[9];
        int  mode;
        bit  lst;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            rand_coord(v[i], mode < 2 ? 0 : mode % 4);
        // degenerate: repeated vertex
        if (mode == 9) begin
            v[6] = v[0]; v[7] = v[1]; v[8] = v[2];
        end
        lst = ($urandom_range(0, 5) == 0);
        send_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], lst);
    endtask

    int mx, mn;

    initial begin
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset config: ref_area zero, unit stiffness
        no_stall = 1'b1;
        send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);                 // degenerate, all zero
        send_tri(0, 0, 0, Q1, 0, 0, 0, Q1, 0, 1'b0);               // unit right triangle
        send_tri(0, 0, 0, 0, Q1, 0, Q1, 0, 0, 1'b1);               // reversed winding, mesh end
        no_stall = 1'b0;
        send_tri(0, 0, 0, Q1, Q1, Q1, 2*Q1, 2*Q1, 2*Q1, 1'b0);     // collinear
        send_tri(mn, mn, mn, mx, mx, mx, mx, mn, 0, 1'b0);         // coordinate extremes
        send_tri(mx, mn, mx, mn, mx, mn, mn, mn, mx, 1'b1);
        send_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1'b1);
        drain();

        // Reference area half a unit, stiffness at maximum
        cfg_write(tapg_pkg::CFG_REF_AREA, 31'd32768);
        cfg_write(tapg_pkg::CFG_STIFFNESS, 31'h7FFF_FFFF);
        send_tri(0, 0, 0, Q1, 0, 0, 0, Q1, 0, 1'b0);               // dev exactly zero
        send_tri(0, 0, 0, 4*Q1, 0, 0, 0, 4*Q1, 0, 1'b0);
        send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);                 // negative dev
        send_tri(mn, 0, mx, mx, mn, 0, 0, mx, mn, 1'b1);           // saturating gradients
        drain();

        // Largest reference area, zero stiffness
        cfg_write(tapg_pkg::CFG_REF_AREA, 31'h7FFF_FFFF);
        cfg_write(tapg_pkg::CFG_STIFFNESS, 31'd0);
        send_tri(mn, mn, mn, mx, mx, mx, mx, mn, 0, 1'b1);
        send_tri(0, 0, 0, Q1, 0, 0, 0, Q1, 0, 1'b1);
        drain();

        // Smallest nonzero reference area, max stiffness: big energy
        cfg_write(tapg_pkg::CFG_REF_AREA, 31'd1);
        cfg_write(tapg_pkg::CFG_STIFFNESS, 31'h7FFF_FFFF);
        send_tri(mn, mn, mn, mx, mx, mx, mx, mn, 0, 1'b0);
        send_tri(mx, mn, mx, mn, mx, mn, mn, mn, mx, 1'b0);
        send_tri(1, 2, 3, -5, 7, -11, 13, -17, 19, 1'b1);
        drain();

        // Random phases, each under its own settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    cfg_write(tapg_pkg::CFG_REF_AREA, 31'd0);
                    cfg_write(tapg_pkg::CFG_STIFFNESS, 31'd65536);
                end
                1: begin
                    cfg_write(tapg_pkg::CFG_REF_AREA, 31'($urandom_range(1, 1 << 22)));
                    cfg_write(tapg_pkg::CFG_STIFFNESS, 31'($urandom));
                end
                2: begin
                    cfg_write(tapg_pkg::CFG_REF_AREA, 31'($urandom));
                    cfg_write(tapg_pkg::CFG_STIFFNESS, 31'($urandom_range(0, 1 << 20)));
                end
                default: begin
                    cfg_write(tapg_pkg::CFG_REF_AREA,
                              31'($urandom_range(0, 1) ? $urandom : 0));
                    cfg_write(tapg_pkg::CFG_STIFFNESS, 31'($urandom));
                end
            endcase
            no_stall = (ph == 3);
            for (int n = 0; n < RAND_ITEMS / 5; n++)
                rand_tri();
            no_stall = 1'b0;
            drain();
        end

        // Wait out the tail, then give the verdict
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("** triangle_area_penalty_gradient_top: PASSED **");
        else
            $display("** triangle_area_penalty_gradient_top: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tapg_pkg.sv
rtl/tapg_serial_unit.sv
rtl/triangle_area_penalty_gradient_top.sv
rtl/tapg_checker.sv
dv/tapg_checker.sv
dv/tb.sv
